// ----- design/pfke_pkg.sv -----
package pfke_pkg;

    // Link encapsulation codes (link_type register)
    localparam logic [1:0] LINK_ETH = 2'd0;
    localparam logic [1:0] LINK_SLL = 2'd1;
    localparam logic [1:0] LINK_RAW = 2'd2;
    localparam logic [1:0] LINK_BAD = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LINK_TYPE = 1'b0;
    localparam logic CFG_OWN_MAC   = 1'b1;

    // Innermost protocol codes
    localparam logic [3:0] PC_UNKNOWN = 4'd0;
    localparam logic [3:0] PC_ETHER   = 4'd1;
    localparam logic [3:0] PC_SLL     = 4'd2;
    localparam logic [3:0] PC_IP      = 4'd3;
    localparam logic [3:0] PC_IP6     = 4'd4;
    localparam logic [3:0] PC_ARP     = 4'd5;
    localparam logic [3:0] PC_TCP     = 4'd6;
    localparam logic [3:0] PC_UDP     = 4'd7;
    localparam logic [3:0] PC_ICMP    = 4'd8;
    localparam logic [3:0] PC_TCP6    = 4'd9;
    localparam logic [3:0] PC_UDP6    = 4'd10;
    localparam logic [3:0] PC_ICMP6   = 4'd11;

    // Direction codes
    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_RX      = 2'd1;
    localparam logic [1:0] DIR_TX      = 2'd2;

    // Which address width was captured
    localparam logic [1:0] AK_NONE = 2'd0;
    localparam logic [1:0] AK_V4   = 2'd1;
    localparam logic [1:0] AK_V6   = 2'd2;

    // Wire constants
    localparam logic [15:0] ETYPE_IP4  = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IP6  = 16'h86dd;
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] SLL_ETHER  = 16'h0004;
    localparam logic [15:0] SLL_PKT_RX = 16'h0000;
    localparam logic [15:0] SLL_PKT_TX = 16'h0004;
    localparam logic [7:0]  IPP_ICMP   = 8'd1;
    localparam logic [7:0]  IPP_TCP    = 8'd6;
    localparam logic [7:0]  IPP_UDP    = 8'd17;
    localparam logic [7:0]  IPP_ICMP6  = 8'd58;
    localparam logic [3:0]  IPV4_VER   = 4'd4;
    localparam logic [3:0]  IPV6_VER   = 4'd6;

    // Only the first HEAD_BYTES bytes of a frame are visible to the parser
    localparam int HEAD_BYTES = 128;

    // Records between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic         ok;
        logic [3:0]   proto;
        logic [1:0]   rxtx;
        logic [1:0]   akind;
        logic [127:0] src;
        logic [127:0] dst;
        logic [15:0]  sport;
        logic [15:0]  dport;
        logic [15:0]  poff;
        logic [15:0]  len;
        logic         known;
    } t_pfke_rec;

    typedef struct packed {
        logic         parse_ok;
        logic [3:0]   protocol_code;
        logic [1:0]   link_direction;
        logic         swapped;
        logic [127:0] src_addr;
        logic [127:0] dst_addr;
        logic [15:0]  src_port;
        logic [15:0]  dst_port;
        logic [15:0]  payload_offset;
        logic [15:0]  payload_length;
    } t_pfke_key;

endpackage

// ----- design/pfke_front.sv -----
module pfke_front #(
    parameter int MAX_VLAN_TAGS = 2,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [1:0]          i_link_type,
    input  logic [47:0]         i_own_mac,
    output logic                o_push,
    output pfke_pkg::t_pfke_rec o_rec
);
    import pfke_pkg::*;

    localparam int LB = LENGTH_BITS;
    localparam int VW = $clog2(MAX_VLAN_TAGS + 1);

    typedef enum logic [3:0] {
        LY_ETH, LY_SLL, LY_RAW, LY_VLAN, LY_IP4, LY_IP4B,
        LY_IP6, LY_TCP, LY_UDP, LY_ICMP, LY_DONE
    } t_layer;

    typedef struct packed {
        t_layer ly;
        logic   ok;
        logic   arp;
        logic   vlan;
    } t_disp;

    // ethertype dispatch, shared by Ethernet and VLAN tags
    function automatic t_disp dispatch(input logic [15:0] typ, input logic vl_full);
        t_disp r;
        r = '{ly: LY_DONE, ok: 1'b0, arp: 1'b0, vlan: 1'b0};
        case (typ)
            ETYPE_IP4:  r.ly = LY_IP4;
            ETYPE_IP6:  r.ly = LY_IP6;
            ETYPE_ARP:  begin
                r.ok  = 1'b1;
                r.arp = 1'b1;
            end
            ETYPE_VLAN: begin
                if (!vl_full) begin
                    r.ly   = LY_VLAN;
                    r.vlan = 1'b1;
                end
            end
            default:    r.ly = LY_DONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            default: b = mac[7:0];
        endcase
        return b;
    endfunction

    // control
    logic [LB-1:0] r_off, n_off;
    t_layer        r_layer, n_layer, layer;
    logic [7:0]    r_base, n_base;
    logic [VW-1:0] r_vlans, n_vlans;
    logic          r_mdst, n_mdst, r_msrc, n_msrc;
    logic          r_ok, n_ok;
    logic [3:0]    r_proto, n_proto;
    logic [1:0]    r_rxtx, n_rxtx;
    logic [1:0]    r_akind, n_akind;
    logic [15:0]   r_sport, n_sport, r_dport, n_dport, r_poff, n_poff;
    // field captures
    logic [7:0]    r_hi, n_hi;
    logic [15:0]   r_pkt, n_pkt;
    logic [3:0]    r_hl, n_hl, r_thl, n_thl;
    logic          r_fragnz, n_fragnz, r_v6, n_v6;
    logic [7:0]    r_nxt, n_nxt;
    logic [31:0]   r_tport, n_tport;
    logic [127:0]  r_src, n_src, r_dst, n_dst;

    logic [7:0]    d;
    logic [LB-1:0] rel;
    logic [15:0]   typ;
    t_layer        start_layer;
    logic          do_disp, do_l4, src_we, dst_we, icmp_hit;
    logic [7:0]    disp_base, l4_base;
    logic [3:0]    aidx;
    t_disp         dr;

    always_comb begin
        unique case (i_link_type)
            LINK_ETH: start_layer = LY_ETH;
            LINK_SLL: start_layer = LY_SLL;
            LINK_RAW: start_layer = LY_RAW;
            default:  start_layer = LY_DONE;
        endcase
    end

    always_comb begin
        d     = (r_off < LB'(HEAD_BYTES)) ? i_data_byte : 8'h00;
        layer = (r_off == '0) ? start_layer : r_layer;
        rel   = r_off - LB'(r_base);
        typ   = {r_hi, d};
        n_off = (r_off == '1) ? r_off : r_off + 1'b1;
        n_layer = layer;  n_base = r_base;   n_vlans = r_vlans;
        n_mdst = r_mdst;  n_msrc = r_msrc;   n_ok = r_ok;
        n_proto = r_proto; n_rxtx = r_rxtx;  n_akind = r_akind;
        n_sport = r_sport; n_dport = r_dport; n_poff = r_poff;
        n_hi = r_hi; n_pkt = r_pkt; n_hl = r_hl; n_thl = r_thl;
        n_fragnz = r_fragnz; n_v6 = r_v6; n_nxt = r_nxt; n_tport = r_tport;
        n_src = r_src; n_dst = r_dst;
        do_disp = 1'b0; disp_base = r_base;
        do_l4 = 1'b0; l4_base = r_base;
        src_we = 1'b0; dst_we = 1'b0; aidx = '0;
        dr = dispatch(typ, r_vlans >= VW'(MAX_VLAN_TAGS));

        unique case (layer)
            LY_ETH: begin
                if (rel < LB'(6)) begin
                    n_mdst = r_mdst & (d == mac_byte(i_own_mac, 3'(rel)));
                end else if (rel < LB'(12)) begin
                    n_msrc = r_msrc & (d == mac_byte(i_own_mac, 3'(rel - LB'(6))));
                end else if (rel == LB'(12)) begin
                    n_hi = d;
                end else if (rel == LB'(13)) begin
                    if (r_msrc) begin
                        n_rxtx = DIR_TX;
                    end else if (r_mdst) begin
                        n_rxtx = DIR_RX;
                    end
                    n_proto   = PC_ETHER;
                    n_poff    = 16'(r_base) + 16'd14;
                    do_disp   = 1'b1;
                    disp_base = r_base + 8'd14;
                end
            end
            LY_VLAN: begin
                if (rel == LB'(2)) begin
                    n_hi = d;
                end else if (rel == LB'(3)) begin
                    do_disp   = 1'b1;
                    disp_base = r_base + 8'd4;
                end
            end
            LY_SLL: begin
                if (rel == LB'(0)) begin
                    n_pkt[15:8] = d;
                end else if (rel == LB'(1)) begin
                    n_pkt[7:0] = d;
                end else if (rel == LB'(14)) begin
                    n_hi = d;
                end else if (rel == LB'(15)) begin
                    if (r_pkt == SLL_PKT_RX) begin
                        n_rxtx = DIR_RX;
                    end else if (r_pkt == SLL_PKT_TX) begin
                        n_rxtx = DIR_TX;
                    end
                    n_proto = PC_SLL;
                    n_poff  = 16'd16;
                    n_base  = 8'd16;
                    n_ok    = 1'b0;
                    n_layer = LY_DONE;
                    if (typ == SLL_ETHER) begin
                        n_layer = LY_ETH;
                        n_mdst  = 1'b1;
                        n_msrc  = 1'b1;
                    end else if (typ == ETYPE_ARP) begin
                        n_proto = PC_ARP;
                        n_ok    = 1'b1;
                    end else if (typ == ETYPE_IP4) begin
                        n_layer = LY_IP4;
                    end
                end
            end
            LY_RAW: begin
                // first byte carries the version; IPv4 header length comes with it
                n_hl = d[3:0];
                if (d[7:4] == IPV4_VER) begin
                    n_layer = LY_IP4;
                end else if (d[7:4] == IPV6_VER) begin
                    n_layer = LY_IP6;
                end else begin
                    n_layer = LY_DONE;
                end
            end
            LY_IP4: begin
                if (rel == LB'(0)) n_hl = d[3:0];
                if (rel == LB'(6)) n_hi = d;
                if (rel == LB'(7)) n_fragnz = |{r_hi[4:0], d};
                if (rel == LB'(9)) n_nxt = d;
                if (rel >= LB'(12) && rel < LB'(16)) begin
                    src_we = 1'b1;
                    aidx   = 4'(rel - LB'(12));
                end
                if (rel >= LB'(16) && rel < LB'(20)) begin
                    dst_we = 1'b1;
                    aidx   = 4'(rel - LB'(16));
                end
                if (rel == LB'(19)) begin
                    if (r_hl < 4'd5) begin
                        n_layer = LY_DONE;
                        n_ok    = 1'b0;
                    end else begin
                        n_akind = AK_V4;
                        n_proto = PC_IP;
                        n_ok    = 1'b1;
                        if (r_hl == 4'd5) begin
                            if (r_fragnz) begin
                                n_layer = LY_DONE;
                            end else begin
                                do_l4   = 1'b1;
                                l4_base = r_base + 8'd20;
                            end
                        end else begin
                            n_layer = LY_IP4B;
                        end
                    end
                end
            end
            LY_IP4B: begin
                // options present: skip to the end of the header before the transport layer
                if (rel == LB'({r_hl, 2'b00} - 6'd1)) begin
                    if (r_fragnz) begin
                        n_layer = LY_DONE;
                    end else begin
                        do_l4   = 1'b1;
                        l4_base = r_base + {2'b00, r_hl, 2'b00};
                    end
                end
            end
            LY_IP6: begin
                if (rel == LB'(6)) n_nxt = d;
                if (rel >= LB'(8) && rel < LB'(24)) begin
                    src_we = 1'b1;
                    aidx   = 4'(rel - LB'(8));
                end
                if (rel >= LB'(24) && rel < LB'(40)) begin
                    dst_we = 1'b1;
                    aidx   = 4'(rel - LB'(24));
                end
                if (rel == LB'(39)) begin
                    n_akind = AK_V6;
                    n_proto = PC_IP6;
                    do_l4   = 1'b1;
                    l4_base = r_base + 8'd40;
                end
            end
            LY_TCP: begin
                if (rel == LB'(12)) n_thl = d[7:4];
                if (rel == LB'(19)) begin
                    n_layer = LY_DONE;
                    if (r_thl < 4'd5) begin
                        n_ok = 1'b0;
                    end else begin
                        n_ok    = 1'b1;
                        n_sport = r_tport[31:16];
                        n_dport = r_tport[15:0];
                        n_proto = r_v6 ? PC_TCP6 : PC_TCP;
                        n_poff  = 16'(r_base) + 16'({r_thl, 2'b00});
                    end
                end
            end
            LY_UDP: begin
                if (rel == LB'(7)) begin
                    n_layer = LY_DONE;
                    n_ok    = 1'b1;
                    n_sport = r_tport[31:16];
                    n_dport = r_tport[15:0];
                    n_proto = r_v6 ? PC_UDP6 : PC_UDP;
                    n_poff  = 16'(r_base) + 16'd8;
                end
            end
            LY_ICMP: begin
                if (rel == (r_v6 ? LB'(7) : LB'(27))) begin
                    n_layer = LY_DONE;
                    n_ok    = 1'b1;
                    n_sport = {8'h00, r_tport[31:24]};
                    n_dport = {8'h00, r_tport[31:24]};
                    n_proto = r_v6 ? PC_ICMP6 : PC_ICMP;
                end
            end
            default: ;
        endcase

        // transport ports and ICMP type sit in the first four bytes
        if ((layer == LY_TCP || layer == LY_UDP || layer == LY_ICMP) && rel < LB'(4)) begin
            case (rel[1:0])
                2'd0:    n_tport[31:24] = d;
                2'd1:    n_tport[23:16] = d;
                2'd2:    n_tport[15:8]  = d;
                default: n_tport[7:0]   = d;
            endcase
        end

        for (int k = 0; k < 16; k++) begin
            if (src_we && aidx == 4'(k)) n_src[127 - 8*k -: 8] = d;
            if (dst_we && aidx == 4'(k)) n_dst[127 - 8*k -: 8] = d;
        end

        if (do_disp) begin
            n_layer = dr.ly;
            n_ok    = dr.ok;
            n_base  = disp_base;
            if (dr.arp)  n_proto = PC_ARP;
            if (dr.vlan) n_vlans = r_vlans + 1'b1;
        end

        if (do_l4) begin
            icmp_hit = r_v6 ? 1'b0 : 1'b0;
            icmp_hit = (layer == LY_IP6) ? (r_nxt == IPP_ICMP6) : (r_nxt == IPP_ICMP);
            n_poff  = 16'(l4_base);
            n_sport = {8'h00, r_nxt};
            n_dport = {8'h00, r_nxt};
            n_base  = l4_base;
            n_v6    = (layer == LY_IP6);
            n_ok    = 1'b0;
            if (r_nxt == IPP_TCP) begin
                n_layer = LY_TCP;
            end else if (r_nxt == IPP_UDP) begin
                n_layer = LY_UDP;
            end else if (icmp_hit) begin
                n_layer = LY_ICMP;
            end else begin
                n_layer = LY_DONE;
                n_ok    = 1'b1;
            end
        end else begin
            icmp_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hi <= n_hi;   r_pkt <= n_pkt;     r_hl <= n_hl;   r_thl <= n_thl;
            r_fragnz <= n_fragnz; r_v6 <= n_v6; r_nxt <= n_nxt; r_tport <= n_tport;
            r_src <= n_src; r_dst <= n_dst;
        end
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_off <= '0;  r_layer <= LY_DONE; r_base <= '0; r_vlans <= '0;
            r_mdst <= 1'b1; r_msrc <= 1'b1; r_ok <= 1'b0; r_proto <= PC_UNKNOWN;
            r_rxtx <= DIR_UNKNOWN; r_akind <= AK_NONE;
            r_sport <= '0; r_dport <= '0; r_poff <= '0;
        end else if (i_accept) begin
            r_off <= n_off;  r_layer <= n_layer; r_base <= n_base; r_vlans <= n_vlans;
            r_mdst <= n_mdst; r_msrc <= n_msrc; r_ok <= n_ok; r_proto <= n_proto;
            r_rxtx <= n_rxtx; r_akind <= n_akind;
            r_sport <= n_sport; r_dport <= n_dport; r_poff <= n_poff;
        end
    end

    assign o_push = i_accept & i_last_byte;
    assign o_rec  = '{ok: n_ok, proto: n_proto, rxtx: n_rxtx, akind: n_akind,
                      src: n_src, dst: n_dst, sport: n_sport, dport: n_dport,
                      poff: n_poff, len: 16'(n_off), known: (i_link_type != LINK_BAD)};

endmodule

// ----- design/pfke_queue.sv -----
module pfke_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pfke_pkg::t_pfke_rec i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output pfke_pkg::t_pfke_rec o_rec
);
    import pfke_pkg::*;

    localparam int AW = $clog2(Q_DEPTH);

    t_pfke_rec     r_mem [Q_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_rec;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

endmodule

// ----- design/pfke_back.sv -----
module pfke_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pfke_pkg::t_pfke_rec i_rec,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output pfke_pkg::t_pfke_key o_key
);
    import pfke_pkg::*;

    logic         r_valid;
    t_pfke_key    r_key, n_key;
    logic [127:0] src_m, dst_m;
    logic         gt, swap;

    always_comb begin
        case (i_rec.akind)
            AK_V4:   begin
                src_m = {i_rec.src[127:96], 96'h0};
                dst_m = {i_rec.dst[127:96], 96'h0};
            end
            AK_V6:   begin
                src_m = i_rec.src;
                dst_m = i_rec.dst;
            end
            default: begin
                src_m = '0;
                dst_m = '0;
            end
        endcase
        gt   = (src_m > dst_m) || (src_m == dst_m && i_rec.sport > i_rec.dport);
        swap = i_rec.known && (i_rec.rxtx != DIR_UNKNOWN || gt);
        n_key.parse_ok       = i_rec.ok;
        n_key.protocol_code  = i_rec.proto;
        n_key.link_direction = i_rec.rxtx;
        n_key.swapped        = swap;
        n_key.src_addr       = swap ? dst_m : src_m;
        n_key.dst_addr       = swap ? src_m : dst_m;
        n_key.src_port       = swap ? i_rec.dport : i_rec.sport;
        n_key.dst_port       = swap ? i_rec.sport : i_rec.dport;
        n_key.payload_offset = i_rec.poff;
        n_key.payload_length = (i_rec.len > i_rec.poff) ? i_rec.len - i_rec.poff : 16'h0;
    end

    assign o_pop = i_valid && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) r_key <= n_key;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

// ----- design/packet_flow_key_extractor.sv -----
// Flow key extractor: one frame byte per cycle in while not stalled, one flow key per frame out.
// Throughput: one byte per cycle, back to back unless the queue is full; a key may follow every cycle unless stalled.
// The last-byte transaction writes the record into the queue; the key register loads it from the queue head.
// The 2-entry record queue stalls the byte input while full; it fills only while the key side is blocked.
// Reset (synchronous, active low) empties queue and output, restarts the front's byte
// offset, sets link_type to Ethernet and clears own_mac.
module packet_flow_key_extractor #(
    parameter int MAX_VLAN_TAGS = 2,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // key output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_parse_ok,
    output logic [3:0]  o_protocol_code,
    output logic [1:0]  o_link_direction,
    output logic        o_swapped,
    output logic [63:0] o_src_addr_hi,
    output logic [63:0] o_src_addr_lo,
    output logic [63:0] o_dst_addr_hi,
    output logic [63:0] o_dst_addr_lo,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [15:0] o_payload_offset,
    output logic [15:0] o_payload_length,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import pfke_pkg::*;

    logic [1:0]  r_link_type;
    logic [47:0] r_own_mac;
    logic        in_accept, push, q_full, q_valid, pop;
    t_pfke_rec   f_rec, q_rec;
    t_pfke_key   key;

    // the user must write registers only between frames; the block does not enforce it; always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_type <= LINK_ETH;
            r_own_mac   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINK_TYPE: r_link_type <= i_cfg_data[1:0];
                default:       r_own_mac   <= i_cfg_data;
            endcase
        end
    end

    // stall on a full queue; only the last byte writes a record
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // front: per-byte header walk, keeps a live "key if the frame ended here"
    pfke_front #(
        .MAX_VLAN_TAGS (MAX_VLAN_TAGS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_link_type (r_link_type),
        .i_own_mac   (r_own_mac),
        .o_push      (push),
        .o_rec       (f_rec)
    );

    pfke_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (f_rec),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    // back: address masking, endpoint swap (known direction or canonical order), payload length, key register
    pfke_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_rec   (q_rec),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_key   (key)
    );

    assign o_parse_ok       = key.parse_ok;
    assign o_protocol_code  = key.protocol_code;
    assign o_link_direction = key.link_direction;
    assign o_swapped        = key.swapped;
    assign o_src_addr_hi    = key.src_addr[127:64];
    assign o_src_addr_lo    = key.src_addr[63:0];
    assign o_dst_addr_hi    = key.dst_addr[127:64];
    assign o_dst_addr_lo    = key.dst_addr[63:0];
    assign o_src_port       = key.src_port;
    assign o_dst_port       = key.dst_port;
    assign o_payload_offset = key.payload_offset;
    assign o_payload_length = key.payload_length;

endmodule

// ----- design/pfke_checker.sv -----
module pfke_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_parse_ok,
    input logic [3:0]  o_protocol_code,
    input logic [1:0]  o_link_direction,
    input logic        o_swapped,
    input logic [63:0] o_src_addr_hi,
    input logic [15:0] o_src_port,
    input logic [15:0] o_dst_port
);
    import pfke_pkg::*;

    // a stalled key holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_src_addr_hi)
            && $stable(o_src_port) && $stable(o_protocol_code)))
        else $error("stalled key changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("key valid after reset");

    a_dir_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_link_direction != DIR_UNKNOWN) |-> o_swapped)
        else $error("known direction without swap");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_link_direction <= DIR_TX && o_protocol_code <= PC_ICMP6))
        else $error("bad code on key");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_protocol_code == PC_UNKNOWN) |->
            (!o_parse_ok && o_src_port == 16'd0 && o_dst_port == 16'd0
             && o_src_addr_hi == 64'd0))
        else $error("unknown protocol with captured fields");

endmodule

bind packet_flow_key_extractor pfke_checker u_pfke_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_parse_ok       (o_parse_ok),
    .o_protocol_code  (o_protocol_code),
    .o_link_direction (o_link_direction),
    .o_swapped        (o_swapped),
    .o_src_addr_hi    (o_src_addr_hi),
    .o_src_port       (o_src_port),
    .o_dst_port       (o_dst_port)
);
